FILE: rtl/core/paq_pkg.sv
// Types and constants shared by the periodic alarm queue.
// Depends on nothing; the divider, datapath, controller and top files import it.
package paq_pkg;

  localparam int TIME_W = 64;
  localparam int IV_W   = 63;
  localparam int SLOT_W = 3;

  localparam logic [TIME_W-1:0] NO_DEADLINE = 64'h7FFF_FFFF_FFFF_FFFF;

  // One input request as latched by the datapath
  typedef struct packed {
    logic                     req_type;
    logic [SLOT_W-1:0]        slot;
    logic [IV_W-1:0]          interval;
    logic signed [TIME_W-1:0] start_time;
    logic                     periodic;
    logic                     enabled;
    logic signed [TIME_W-1:0] now;
  } in_item_t;

  // One result
  typedef struct packed {
    logic                     fired;
    logic [SLOT_W-1:0]        fired_slot;
    logic                     last;
    logic signed [TIME_W-1:0] next_delta;
  } out_item_t;

  typedef enum logic {
    REQ_PROGRAM = 1'b0,
    REQ_TICK    = 1'b1
  } req_e;

  // Commands from the controller to the datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_QSEL0,
    CMD_QSEL1,
    CMD_DEQ_STEP,
    CMD_DEQ_END,
    CMD_SET,
    CMD_CLR_DL,
    CMD_DL_BASE,
    CMD_DIV_START,
    CMD_DL_SKIP,
    CMD_INS_STEP,
    CMD_INS_END,
    CMD_HEAD_STEP,
    CMD_TAKE,
    CMD_BEST,
    CMD_EMIT_FIRE,
    CMD_EMIT_LAST
  } cmd_e;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tick;
    logic slot_ok;
    logic scan_last;
    logic en_iv;
    logic per_iv;
    logic per;
    logic skip;
    logic found;
    logic expired;
    logic guard_full;
    logic qsel;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_DEQ,
    S_DEQ_END,
    S_SET,
    S_BASE,
    S_PER_CHK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SKIP,
    S_INS,
    S_INS_END,
    S_CLR,
    S_EMIT_FIRE,
    S_HEAD,
    S_HEAD_CHK,
    S_TAKE,
    S_NEXTQ,
    S_FIN_START,
    S_FIN_HEAD,
    S_FIN_BEST,
    S_EMIT_LAST
  } state_e;

endpackage

FILE: rtl/core/paq_in_if.sv
// Request channel of the periodic alarm queue: valid/ready plus payload.
// Depends on nothing.
interface paq_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [2:0]         slot;
  logic [62:0]        interval;
  logic signed [63:0] start_time;
  logic               periodic;
  logic               enabled;
  logic signed [63:0] now;

  modport source (output valid, req_type, slot, interval, start_time, periodic, enabled, now,
                  input ready);
  modport sink   (input valid, req_type, slot, interval, start_time, periodic, enabled, now,
                  output ready);
endinterface

FILE: rtl/core/paq_out_if.sv
// Result channel of the periodic alarm queue: valid/ready plus payload.
// Depends on nothing.
interface paq_out_if;
  logic               valid;
  logic               ready;
  logic               fired;
  logic [2:0]         fired_slot;
  logic               last;
  logic signed [63:0] next_delta;

  modport source (output valid, fired, fired_slot, last, next_delta, input ready);
  modport sink   (input valid, fired, fired_slot, last, next_delta, output ready);
endinterface

FILE: rtl/core/paq_div.sv
// Bit-serial remainder unit: one quotient bit per cycle.
// Depends on paq_pkg.
module paq_div
  import paq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IV_W-1:0] dividend_i,
  input  logic [IV_W-1:0] divisor_i,
  output logic            done_o,
  output logic [IV_W-1:0] rem_o
);

  localparam int CW = $clog2(IV_W + 1);

  logic [IV_W-1:0] dvd_q;
  logic [IV_W-1:0] rem_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;
  logic [IV_W:0]   rem_sh;

  assign rem_sh = {rem_q, dvd_q[IV_W-1]};

  // Restoring step: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(IV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[IV_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, divisor_i}) begin
        rem_q <= IV_W'(rem_sh - {1'b0, divisor_i});
      end else begin
        rem_q <= rem_sh[IV_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/paq_dpath.sv
// Datapath: slot tables, scan counter, work registers and result register.
// Depends on paq_pkg and paq_div.
module paq_dpath
  import paq_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  in_item_t   req_i,
  output dp_status_t status_o,
  output logic       out_vld_o,
  output out_item_t  out_o,
  input  logic       out_rdy_i
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GW = $clog2(SLOTS + 1);

  // slot tables
  logic [IV_W-1:0]   iv_q [SLOTS];
  logic [TIME_W-1:0] st_q [SLOTS];
  logic [TIME_W-1:0] dl_q [SLOTS];
  logic              per_q [SLOTS];
  logic              en_q [SLOTS];
  logic              qd_q [SLOTS];
  logic              ch_q [SLOTS];
  logic [SW-1:0]     rk_q [SLOTS];

  // work registers
  in_item_t          req_q;
  logic              slot_ok_q;
  logic [SW-1:0]     cur_q, idx_q, hidx_q, pos_q;
  logic              curq_q, qsel_q, found_q;
  logic [GW-1:0]     guard_q;
  logic [TIME_W-1:0] wdl_q, best_q;
  logic              out_vld_q;
  out_item_t         out_q;

  logic [TIME_W-1:0] now_w, nowmw, head_diff, best_d, cand;
  logic [TIME_W-1:0] cur_st;
  logic              scan_last, hit, rel;
  logic              div_done;
  logic [IV_W-1:0]   rem;

  assign now_w     = req_q.now;
  assign scan_last = (idx_q == SW'(SLOTS - 1));
  assign nowmw     = now_w - wdl_q;
  assign head_diff = now_w - dl_q[hidx_q];
  assign cur_st    = st_q[cur_q];
  assign rel       = (cur_st == '0) || cur_st[TIME_W-1];
  assign hit       = qd_q[idx_q] && (ch_q[idx_q] == qsel_q) && (rk_q[idx_q] == '0);
  assign cand      = dl_q[hidx_q] - now_w;
  assign best_d    = ($signed(best_q) <= $signed(cand)) ? best_q : cand;

  paq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i == CMD_DIV_START),
    .dividend_i (nowmw[IV_W-1:0]),
    .divisor_i  (iv_q[cur_q]),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // status towards the controller
  always_comb begin
    status_o.tick       = (req_q.req_type == REQ_TICK);
    status_o.slot_ok    = slot_ok_q;
    status_o.scan_last  = scan_last;
    status_o.en_iv      = en_q[cur_q] && (iv_q[cur_q] != '0);
    status_o.per_iv     = per_q[cur_q] && (iv_q[cur_q] != '0);
    status_o.per        = per_q[cur_q];
    status_o.skip       = !nowmw[TIME_W-1];
    status_o.found      = found_q;
    status_o.expired    = !head_diff[TIME_W-1];
    status_o.guard_full = (guard_q == GW'(SLOTS));
    status_o.qsel       = qsel_q;
    status_o.div_done   = div_done;
    status_o.out_free   = !out_vld_q || out_rdy_i;
  end

  // slot tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        iv_q[i]  <= '0;
        st_q[i]  <= '0;
        dl_q[i]  <= '0;
        per_q[i] <= 1'b0;
        en_q[i]  <= 1'b1;
        qd_q[i]  <= 1'b0;
        ch_q[i]  <= 1'b0;
        rk_q[i]  <= '0;
      end
    end else begin
      case (cmd_i)
        CMD_DEQ_STEP: begin
          if (qd_q[cur_q] && qd_q[idx_q] && (ch_q[idx_q] == ch_q[cur_q]) &&
              (rk_q[idx_q] > rk_q[cur_q])) begin
            rk_q[idx_q] <= rk_q[idx_q] - 1'b1;
          end
        end
        CMD_DEQ_END: begin
          qd_q[cur_q] <= 1'b0;
          rk_q[cur_q] <= '0;
        end
        CMD_SET: begin
          dl_q[cur_q]  <= '0;
          iv_q[cur_q]  <= req_q.interval;
          st_q[cur_q]  <= req_q.start_time;
          per_q[cur_q] <= req_q.periodic;
          en_q[cur_q]  <= req_q.enabled;
        end
        CMD_CLR_DL: dl_q[cur_q] <= '0;
        CMD_INS_STEP: begin
          if (qd_q[idx_q] && (ch_q[idx_q] == curq_q) &&
              !($signed(dl_q[idx_q]) <= $signed(wdl_q))) begin
            rk_q[idx_q] <= rk_q[idx_q] + 1'b1;
          end
        end
        CMD_INS_END: begin
          dl_q[cur_q] <= wdl_q;
          qd_q[cur_q] <= 1'b1;
          ch_q[cur_q] <= curq_q;
          rk_q[cur_q] <= pos_q;
        end
        default: ;
      endcase
    end
  end

  // control registers: scan counter, queue select, guard, head flag, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      qsel_q    <= 1'b0;
      guard_q   <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      slot_ok_q <= 1'b0;
    end else begin
      if (cmd_i == CMD_DEQ_STEP || cmd_i == CMD_INS_STEP || cmd_i == CMD_HEAD_STEP) begin
        idx_q <= scan_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i == CMD_HEAD_STEP) begin
        found_q <= hit || (found_q && (idx_q != '0));
      end
      case (cmd_i)
        CMD_LOAD:  slot_ok_q <= (int'(req_i.slot) < SLOTS);
        CMD_QSEL0: begin
          qsel_q  <= 1'b0;
          guard_q <= '0;
        end
        CMD_QSEL1: begin
          qsel_q  <= 1'b1;
          guard_q <= '0;
        end
        CMD_BEST:  qsel_q <= 1'b1;
        CMD_TAKE:  guard_q <= guard_q + 1'b1;
        default: ;
      endcase
      if (cmd_i == CMD_EMIT_FIRE || cmd_i == CMD_EMIT_LAST) begin
        out_vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // work payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_HEAD_STEP && hit) begin
      hidx_q <= idx_q;
    end
    case (cmd_i)
      CMD_LOAD: begin
        req_q  <= req_i;
        cur_q  <= SW'(req_i.slot);
        best_q <= NO_DEADLINE;
      end
      CMD_SET:  curq_q <= (req_q.start_time == '0) || req_q.start_time[TIME_W-1];
      CMD_TAKE: begin
        cur_q  <= hidx_q;
        curq_q <= qsel_q;
      end
      CMD_DL_BASE: begin
        pos_q <= '0;
        if (!rel) begin
          wdl_q <= cur_st + {1'b0, iv_q[cur_q]};
        end else if (dl_q[cur_q] == '0) begin
          wdl_q <= now_w + {1'b0, iv_q[cur_q]};
        end else begin
          wdl_q <= dl_q[cur_q];
        end
      end
      CMD_DL_SKIP: wdl_q <= now_w - {1'b0, rem} + {1'b0, iv_q[cur_q]};
      CMD_INS_STEP: begin
        if (qd_q[idx_q] && (ch_q[idx_q] == curq_q) &&
            ($signed(dl_q[idx_q]) <= $signed(wdl_q))) begin
          pos_q <= pos_q + 1'b1;
        end
      end
      CMD_BEST: begin
        if (found_q) begin
          best_q <= best_d;
        end
      end
      CMD_EMIT_FIRE: begin
        out_q.fired      <= 1'b1;
        out_q.fired_slot <= SLOT_W'(cur_q);
        out_q.last       <= 1'b0;
        out_q.next_delta <= '0;
      end
      CMD_EMIT_LAST: begin
        out_q.fired      <= 1'b0;
        out_q.fired_slot <= '0;
        out_q.last       <= 1'b1;
        out_q.next_delta <= best_q;
      end
      default: ;
    endcase
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule

FILE: rtl/core/paq_ctrl.sv
// Controller state machine: sequences the datapath scans per request.
// Depends on paq_pkg.
module paq_ctrl
  import paq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_vld_i,
  output logic       in_rdy_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;
  state_e after_enq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = CMD_NONE;
    in_rdy_o  = 1'b0;
    after_enq = status_i.tick ? S_EMIT_FIRE : S_FIN_START;
    case (state_q)
      S_IDLE: begin
        in_rdy_o = 1'b1;
        if (in_vld_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.tick) begin
          cmd_o   = CMD_QSEL0;
          state_d = S_HEAD;
        end else if (status_i.slot_ok) begin
          state_d = S_DEQ;
        end else begin
          state_d = S_FIN_START;
        end
      end
      S_DEQ: begin
        cmd_o = CMD_DEQ_STEP;
        if (status_i.scan_last) state_d = S_DEQ_END;
      end
      S_DEQ_END: begin
        cmd_o = CMD_DEQ_END;
        if (!status_i.tick)       state_d = S_SET;
        else if (status_i.per_iv) state_d = S_BASE;
        else                      state_d = S_CLR;
      end
      S_SET: begin
        cmd_o   = CMD_SET;
        state_d = S_BASE;
      end
      S_BASE: begin
        if (status_i.en_iv) begin
          cmd_o   = CMD_DL_BASE;
          state_d = S_PER_CHK;
        end else begin
          state_d = after_enq;
        end
      end
      S_PER_CHK: state_d = (status_i.per && status_i.skip) ? S_DIV_GO : S_INS;
      S_DIV_GO: begin
        cmd_o   = CMD_DIV_START;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (status_i.div_done) state_d = S_SKIP;
      S_SKIP: begin
        cmd_o   = CMD_DL_SKIP;
        state_d = S_INS;
      end
      S_INS: begin
        cmd_o = CMD_INS_STEP;
        if (status_i.scan_last) state_d = S_INS_END;
      end
      S_INS_END: begin
        cmd_o   = CMD_INS_END;
        state_d = after_enq;
      end
      S_CLR: begin
        cmd_o   = CMD_CLR_DL;
        state_d = S_EMIT_FIRE;
      end
      S_EMIT_FIRE: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_EMIT_FIRE;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd_o = CMD_HEAD_STEP;
        if (status_i.scan_last) state_d = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        if (status_i.guard_full || !status_i.found || !status_i.expired) state_d = S_NEXTQ;
        else state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o   = CMD_TAKE;
        state_d = S_DEQ;
      end
      S_NEXTQ: begin
        if (status_i.qsel) begin
          state_d = S_FIN_START;
        end else begin
          cmd_o   = CMD_QSEL1;
          state_d = S_HEAD;
        end
      end
      S_FIN_START: begin
        cmd_o   = CMD_QSEL0;
        state_d = S_FIN_HEAD;
      end
      S_FIN_HEAD: begin
        cmd_o = CMD_HEAD_STEP;
        if (status_i.scan_last) state_d = S_FIN_BEST;
      end
      S_FIN_BEST: begin
        cmd_o   = CMD_BEST;
        state_d = status_i.qsel ? S_EMIT_LAST : S_FIN_HEAD;
      end
      S_EMIT_LAST: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_EMIT_LAST;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/periodic_alarm_queue.sv
// Periodic alarm queue: SLOTS alarm slots kept in two deadline-sorted queues.
// A program request (req_type 0) cancels one slot, loads its settings and
// queues it when enabled with a nonzero interval; a tick request (1) fires
// every expired alarm, queue 0 first, in deadline order.
// Channels: req_i (sink) and res_o (source), valid/ready, a request moves at
// an edge with both high. Each request yields zero or more fired results and
// one final result (last = 1) with the ticks to the nearest deadline.
// Timing: one request at a time. Every table search is a scan of one slot
// per cycle. A program request does a dequeue scan and an insert scan; a
// periodic deadline that must catch up also uses the bit-serial remainder.
// A tick scans the queue heads, and each fired alarm costs a dequeue scan
// and, when it is queued again, an insert scan (and the remainder when it
// catches up); the final result needs a head scan of each queue, queue 0 first.
// Results leave through an output register: a stalled receiver only holds
// the sequencer when a further result is due. req_i.ready is high only
// between requests. Reset clears all slots (enabled, not queued).
module periodic_alarm_queue
  import paq_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  paq_in_if.sink    req_i,
  paq_out_if.source res_o
);

  cmd_e       cmd;
  dp_status_t status;
  in_item_t   req_item;
  out_item_t  res_item;
  logic       res_vld;

  always_comb begin
    req_item.req_type   = req_i.req_type;
    req_item.slot       = req_i.slot;
    req_item.interval   = req_i.interval;
    req_item.start_time = req_i.start_time;
    req_item.periodic   = req_i.periodic;
    req_item.enabled    = req_i.enabled;
    req_item.now        = req_i.now;
  end

  paq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (req_i.valid),
    .in_rdy_o (req_i.ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  paq_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .req_i     (req_item),
    .status_o  (status),
    .out_vld_o (res_vld),
    .out_o     (res_item),
    .out_rdy_i (res_o.ready)
  );

  assign res_o.valid      = res_vld;
  assign res_o.fired      = res_item.fired;
  assign res_o.fired_slot = res_item.fired_slot;
  assign res_o.last       = res_item.last;
  assign res_o.next_delta = res_item.next_delta;

endmodule
